[hw/rtl/mafhd_pkg.sv]
// Shared types, codes, rate tables and reciprocal constants for the MPEG audio
// frame header decoder. No dependencies; the decoder top and the length unit import it.
`default_nettype none

package mafhd_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_SYNC    = 3'd1,
    ST_RSV_VERSION = 3'd2,
    ST_RSV_LAYER   = 3'd3,
    ST_BAD_BITRATE = 3'd4,
    ST_BAD_RATE    = 3'd5
  } status_t;

  // Sample rate index, also selects the divisor family of the length unit
  typedef enum logic [1:0] {
    RATE_44K = 2'd0,
    RATE_48K = 2'd1,
    RATE_32K = 2'd2,
    RATE_RSV = 2'd3
  } rate_base_t;

  localparam logic [1:0] VER_25  = 2'd0;
  localparam logic [1:0] VER_RSV = 2'd1;
  localparam logic [1:0] VER_2   = 2'd2;
  localparam logic [1:0] VER_1   = 2'd3;

  localparam logic [1:0] LAYER_RSV = 2'd0;
  localparam logic [1:0] LAYER_1   = 2'd1;
  localparam logic [1:0] LAYER_2   = 2'd2;
  localparam logic [1:0] LAYER_3   = 2'd3;

  localparam logic [10:0] SYNC_PATTERN = 11'h7FF;

  // Reciprocal divide: q0 = (y * RECIP) >> RECIP_SHIFT, then one correction step
  localparam int          RECIP_SHIFT = 24;
  localparam int          QUOT_W      = 12;
  localparam logic [19:0] RECIP_441   = 20'd38043;
  localparam logic [19:0] RECIP_48    = 20'd349525;
  localparam logic [19:0] RECIP_32    = 20'd524288;
  localparam logic [8:0]  DIV_441     = 9'd441;
  localparam logic [8:0]  DIV_48      = 9'd48;
  localparam logic [8:0]  DIV_32      = 9'd32;

  // Columns: V1 L1, V1 L2, V1 L3, V2/2.5 L1, V2/2.5 L2 and L3
  localparam logic [8:0] KBPS_TABLE [16][5] = '{
    '{9'd0,   9'd0,   9'd0,   9'd0,   9'd0  },
    '{9'd32,  9'd32,  9'd32,  9'd32,  9'd8  },
    '{9'd64,  9'd48,  9'd40,  9'd48,  9'd16 },
    '{9'd96,  9'd56,  9'd48,  9'd56,  9'd24 },
    '{9'd128, 9'd64,  9'd56,  9'd64,  9'd32 },
    '{9'd160, 9'd80,  9'd64,  9'd80,  9'd40 },
    '{9'd192, 9'd96,  9'd80,  9'd96,  9'd48 },
    '{9'd224, 9'd112, 9'd96,  9'd112, 9'd56 },
    '{9'd256, 9'd128, 9'd112, 9'd128, 9'd64 },
    '{9'd288, 9'd160, 9'd128, 9'd144, 9'd80 },
    '{9'd320, 9'd192, 9'd160, 9'd160, 9'd96 },
    '{9'd352, 9'd224, 9'd192, 9'd176, 9'd112},
    '{9'd384, 9'd256, 9'd224, 9'd192, 9'd128},
    '{9'd416, 9'd320, 9'd256, 9'd224, 9'd144},
    '{9'd448, 9'd384, 9'd320, 9'd256, 9'd160},
    '{9'd0,   9'd0,   9'd0,   9'd0,   9'd0  }
  };

  typedef struct packed {
    status_t     status;
    logic [1:0]  mpeg_version;
    logic [1:0]  layer_number;
    logic        crc_protected;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic        padding_bit;
    logic [1:0]  channel_mode;
    logic [1:0]  mode_extension;
    logic [2:0]  flag_bits;
    logic [1:0]  emphasis_code;
  } hdr_t;

  // Length request: numerator scale (slots * 2^shift, times 10 for 44.1k family)
  typedef struct packed {
    logic [12:0] scale;
    rate_base_t  base;
  } len_req_t;

  function automatic logic [8:0] kbps_lookup(input logic [3:0] brx, input logic [2:0] col);
    logic [8:0] val;
    val = 9'd0;
    if (col <= 3'd4) begin
      val = KBPS_TABLE[brx][col];
    end
    return val;
  endfunction

  function automatic logic [15:0] rate_base_hz(input rate_base_t base);
    logic [15:0] hz;
    unique case (base)
      RATE_44K: hz = 16'd44100;
      RATE_48K: hz = 16'd48000;
      RATE_32K: hz = 16'd32000;
      default:  hz = 16'd0;
    endcase
    return hz;
  endfunction

  function automatic logic [19:0] recip_of(input rate_base_t base);
    logic [19:0] m;
    unique case (base)
      RATE_44K: m = RECIP_441;
      RATE_48K: m = RECIP_48;
      default:  m = RECIP_32;
    endcase
    return m;
  endfunction

  function automatic logic [8:0] divisor_of(input rate_base_t base);
    logic [8:0] d;
    unique case (base)
      RATE_44K: d = DIV_441;
      RATE_48K: d = DIV_48;
      default:  d = DIV_32;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mafhd_len_div.sv]
// Frame length unit: four register stages that form the numerator, divide by a
// constant-family sample rate through a reciprocal multiply, and correct. Uses mafhd_pkg.
`default_nettype none

module mafhd_len_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire mafhd_pkg::hdr_t     in_hdr,
  input  wire mafhd_pkg::len_req_t in_req,
  output logic                   out_valid,
  output mafhd_pkg::hdr_t          out_hdr,
  output logic [11:0]            out_bytes
);
  import mafhd_pkg::*;

  // Stage D1: numerator y = kbps * scale
  logic        d1_valid;
  hdr_t        d1_hdr;
  rate_base_t  d1_base;
  logic [19:0] d1_y;
  logic [21:0] y_full;

  // Stage D2: estimated quotient
  logic        d2_valid;
  hdr_t        d2_hdr;
  rate_base_t  d2_base;
  logic [19:0] d2_y;
  logic [QUOT_W-1:0] d2_q0;
  logic [39:0] prod;

  // Stage D3: back-multiplied estimate
  logic        d3_valid;
  hdr_t        d3_hdr;
  rate_base_t  d3_base;
  logic [19:0] d3_y;
  logic [QUOT_W-1:0] d3_q0;
  logic [19:0] d3_qd;
  logic [20:0] qd_full;

  // Stage D4 logic: remainder check, padding, slot scaling
  logic [19:0] rem;
  logic [8:0]  div_d4;
  logic [QUOT_W-1:0] q_fix;
  logic [QUOT_W-1:0] q_pad;
  logic [11:0] bytes_next;

  assign y_full = in_hdr.bitrate_kbps * in_req.scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid <= 1'b0;
    end else begin
      d1_valid <= in_valid;
    end
    d1_hdr  <= in_hdr;
    d1_base <= in_req.base;
    d1_y    <= y_full[19:0];
  end

  assign prod = d1_y * recip_of(d1_base);

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_valid <= 1'b0;
    end else begin
      d2_valid <= d1_valid;
    end
    d2_hdr  <= d1_hdr;
    d2_base <= d1_base;
    d2_y    <= d1_y;
    d2_q0   <= prod[RECIP_SHIFT +: QUOT_W];
  end

  assign qd_full = d2_q0 * divisor_of(d2_base);

  always_ff @(posedge clk) begin
    if (rst) begin
      d3_valid <= 1'b0;
    end else begin
      d3_valid <= d2_valid;
    end
    d3_hdr  <= d2_hdr;
    d3_base <= d2_base;
    d3_y    <= d2_y;
    d3_q0   <= d2_q0;
    d3_qd   <= qd_full[19:0];
  end

  // Estimate is never high and at most one low: one compare settles it
  always_comb begin
    div_d4 = divisor_of(d3_base);
    rem    = d3_y - d3_qd;
    q_fix  = d3_q0 + ((rem >= {11'd0, div_d4}) ? 12'd1 : 12'd0);
    q_pad  = q_fix + {11'd0, d3_hdr.padding_bit};
    if (d3_hdr.status != ST_OK) begin
      bytes_next = 12'd0;
    end else if (d3_hdr.layer_number == LAYER_1) begin
      bytes_next = {q_pad[9:0], 2'b00};
    end else begin
      bytes_next = q_pad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= d3_valid;
    end
    out_hdr   <= d3_hdr;
    out_bytes <= bytes_next;
  end

  // A valid header always yields a nonzero frame length
  a_ok_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_hdr.status == ST_OK) |-> out_bytes != 12'd0)
    else $error("ok header with zero frame length");

  // Remainder of the estimate before correction stays below twice the divisor
  a_one_correction: assert property (@(posedge clk) disable iff (rst)
    d3_valid && (d3_hdr.status == ST_OK) |-> rem < {10'd0, div_d4, 1'b0})
    else $error("quotient estimate off by more than one");

endmodule

`default_nettype wire

[hw/rtl/mpeg_audio_frame_header_decoder_unit.sv]
// Top level of the MPEG audio frame header decoder: field split, table lookup
// and status in stage S1, then the mafhd_len_div length pipeline. Uses mafhd_pkg.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+---------------------------------------
//   header in | start, busy (beat: start & | header_word
//             | !busy)                     |
//   result    | strobe (one cycle, no      | status, mpeg_version, layer_number, ...
//             | backpressure)              | emphasis_code, frame_bytes
//
// One header enters per cycle; its result passes the S1 decode register, then the
// four stages of the length unit, before it strobes.
// The latency is set by the length divide: multiply, reciprocal multiply,
// back-multiply, then remainder correction, each behind its own register.
// busy stays low: the pipeline never holds, since the receiver cannot stall.
// Synchronous reset clears the valid bits only; items in flight are dropped.
`default_nettype none

module mpeg_audio_frame_header_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] header_word,
  output logic             strobe,
  output logic [2:0]       status,
  output logic [1:0]       mpeg_version,
  output logic [1:0]       layer_number,
  output logic             crc_protected,
  output logic [8:0]       bitrate_kbps,
  output logic [15:0]      sample_rate_hz,
  output logic             padding_bit,
  output logic [1:0]       channel_mode,
  output logic [1:0]       mode_extension,
  output logic [2:0]       flag_bits,
  output logic [1:0]       emphasis_code,
  output logic [11:0]      frame_bytes
);
  import mafhd_pkg::*;

  logic       accept;

  // Raw header fields
  logic [1:0] ver;
  logic [1:0] lid;
  logic [1:0] layer;
  logic [3:0] brx;
  rate_base_t srx;
  logic       is_v1;
  logic [1:0] rate_shift;
  logic [2:0] kbps_col;

  // Decoded values
  logic [8:0]  kbps;
  logic [15:0] rate;
  status_t     st;
  logic [7:0]  slot_k;
  logic [9:0]  slot_k_sh;
  logic [12:0] scale;
  hdr_t        hdr_next;
  len_req_t    req_next;

  // Stage S1 registers
  logic     s1_valid;
  hdr_t     s1_hdr;
  len_req_t s1_req;

  // Length unit results
  logic  len_valid;
  hdr_t  len_hdr;
  logic [11:0] len_bytes;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    ver   = header_word[20:19];
    lid   = header_word[18:17];
    layer = 2'd0 - lid;               // layer bits count down: 3 -> Layer I
    brx   = header_word[15:12];
    srx   = rate_base_t'(header_word[11:10]);
    is_v1 = (ver == VER_1);

    // MPEG-2 halves the sample rate, MPEG-2.5 quarters it
    if (is_v1) begin
      rate_shift = 2'd0;
    end else if (ver == VER_2) begin
      rate_shift = 2'd1;
    end else begin
      rate_shift = 2'd2;
    end

    // MPEG-2 and 2.5 share one column set; Layers II and III share a column there
    if (is_v1) begin
      kbps_col = {1'b0, layer - 2'd1};
    end else if (layer == LAYER_1) begin
      kbps_col = 3'd3;
    end else begin
      kbps_col = 3'd4;
    end

    kbps = 9'd0;
    rate = 16'd0;
    if (ver != VER_RSV) begin
      rate = rate_base_hz(srx) >> rate_shift;
      if (layer != LAYER_RSV) begin
        kbps = kbps_lookup(brx, kbps_col);
      end
    end

    // Lowest fault code wins
    if (header_word[31:21] != SYNC_PATTERN) begin
      st = ST_BAD_SYNC;
    end else if (ver == VER_RSV) begin
      st = ST_RSV_VERSION;
    end else if (layer == LAYER_RSV) begin
      st = ST_RSV_LAYER;
    end else if (kbps == 9'd0) begin
      st = ST_BAD_BITRATE;
    end else if (rate == 16'd0) begin
      st = ST_BAD_RATE;
    end else begin
      st = ST_OK;
    end

    // Frame length = K * kbps * 1000 / rate. With rate = base >> shift this is
    // K * kbps * 2^shift * 1000 / base: 1000/44100 = 10/441, 1000/48000 = 1/48,
    // 1000/32000 = 1/32. Fold K, 2^shift and the factor 10 into one scale.
    if (layer == LAYER_1) begin
      slot_k = 8'd12;
    end else if ((layer == LAYER_3) && !is_v1) begin
      slot_k = 8'd72;
    end else begin
      slot_k = 8'd144;
    end
    slot_k_sh = {2'b00, slot_k} << rate_shift;
    if (srx == RATE_44K) begin
      scale = ({3'b000, slot_k_sh} << 3) + ({3'b000, slot_k_sh} << 1);
    end else begin
      scale = {3'b000, slot_k_sh};
    end

    hdr_next.status         = st;
    hdr_next.mpeg_version   = ver;
    hdr_next.layer_number   = layer;
    hdr_next.crc_protected  = ~header_word[16];
    hdr_next.bitrate_kbps   = kbps;
    hdr_next.sample_rate_hz = rate;
    hdr_next.padding_bit    = header_word[9];
    hdr_next.channel_mode   = header_word[7:6];
    hdr_next.mode_extension = header_word[5:4];
    hdr_next.flag_bits      = {header_word[8], header_word[3], header_word[2]};
    hdr_next.emphasis_code  = header_word[1:0];

    req_next.scale = scale;
    req_next.base  = srx;
  end

  // S1: hold the decoded header; valid follows the accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_hdr <= hdr_next;
    s1_req <= req_next;
  end

  mafhd_len_div u_len_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_hdr    (s1_hdr),
    .in_req    (s1_req),
    .out_valid (len_valid),
    .out_hdr   (len_hdr),
    .out_bytes (len_bytes)
  );

  // Result ports come straight from the length unit's output registers
  assign strobe         = len_valid;
  assign status         = len_hdr.status;
  assign mpeg_version   = len_hdr.mpeg_version;
  assign layer_number   = len_hdr.layer_number;
  assign crc_protected  = len_hdr.crc_protected;
  assign bitrate_kbps   = len_hdr.bitrate_kbps;
  assign sample_rate_hz = len_hdr.sample_rate_hz;
  assign padding_bit    = len_hdr.padding_bit;
  assign channel_mode   = len_hdr.channel_mode;
  assign mode_extension = len_hdr.mode_extension;
  assign flag_bits      = len_hdr.flag_bits;
  assign emphasis_code  = len_hdr.emphasis_code;
  assign frame_bytes    = len_bytes;

  // Every accepted beat strobes out through the S1 and length-unit registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 strobe)
    else $error("accepted header produced no result");

  // No result strobe without an earlier accepted beat
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accept && !rst, 5))
    else $error("result strobe without a header");

  a_fault_len_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && (status != ST_OK) |-> frame_bytes == 12'd0)
    else $error("frame length reported on faulty header");

  // Layer I frames are whole four-byte slots
  a_layer1_slots: assert property (@(posedge clk) disable iff (rst)
    strobe && (status == ST_OK) && (layer_number == LAYER_1) |-> frame_bytes[1:0] == 2'b00)
    else $error("layer I frame length not slot aligned");

endmodule

`default_nettype wire

[test/mpeg_audio_frame_header_decoder_unit_tb.sv]
// Self-checking bench for mpeg_audio_frame_header_decoder_unit: directed header table, then
// random frame headers, each checked against a behavioral decoder below or typed-in values.
// Depends on mafhd_pkg (status codes, version and layer codes) and the decoder RTL.
`default_nettype none

module mpeg_audio_frame_header_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mafhd_pkg::*;

  localparam int RANDOM_HEADERS = 1927;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int DIRECTED_ROWS  = 23;

  typedef struct {
    status_t     status;
    logic [1:0]  mpeg_version;
    logic [1:0]  layer_number;
    logic        crc_protected;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic        padding_bit;
    logic [1:0]  channel_mode;
    logic [1:0]  mode_extension;
    logic [2:0]  flag_bits;
    logic [1:0]  emphasis_code;
    logic [11:0] frame_bytes;
  } decoded_hdr_t;

  // One directed header; when fixed_result is set, status and frame length are typed in
  typedef struct packed {
    logic [31:0] word;
    logic        fixed_result;
    status_t     status;
    logic [11:0] frame_bytes;
  } header_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] header_word;
  logic        strobe;
  logic [2:0]  status;
  logic [1:0]  mpeg_version;
  logic [1:0]  layer_number;
  logic        crc_protected;
  logic [8:0]  bitrate_kbps;
  logic [15:0] sample_rate_hz;
  logic        padding_bit;
  logic [1:0]  channel_mode;
  logic [1:0]  mode_extension;
  logic [2:0]  flag_bits;
  logic [1:0]  emphasis_code;
  logic [11:0] frame_bytes;

  // Typed-in result of the header being offered, read when its beat is taken
  logic        row_fixed;
  status_t     row_status;
  logic [11:0] row_bytes;

  decoded_hdr_t pending_decodes[$];
  header_row_t  header_rows [DIRECTED_ROWS];
  bit           beat_seen;
  int           mismatches;
  int unsigned  cycle_count;

  mpeg_audio_frame_header_decoder_unit dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .header_word    (header_word),
    .strobe         (strobe),
    .status         (status),
    .mpeg_version   (mpeg_version),
    .layer_number   (layer_number),
    .crc_protected  (crc_protected),
    .bitrate_kbps   (bitrate_kbps),
    .sample_rate_hz (sample_rate_hz),
    .padding_bit    (padding_bit),
    .channel_mode   (channel_mode),
    .mode_extension (mode_extension),
    .flag_bits      (flag_bits),
    .emphasis_code  (emphasis_code),
    .frame_bytes    (frame_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bitrate table; columns V1 L1, V1 L2, V1 L3, V2/2.5 L1, V2/2.5 L2 and L3
  function automatic logic [8:0] table_kbps(int col, logic [3:0] idx);
    logic [8:0] row [5];
    case (idx)
      4'd1:    row = '{9'd32,  9'd32,  9'd32,  9'd32,  9'd8};
      4'd2:    row = '{9'd64,  9'd48,  9'd40,  9'd48,  9'd16};
      4'd3:    row = '{9'd96,  9'd56,  9'd48,  9'd56,  9'd24};
      4'd4:    row = '{9'd128, 9'd64,  9'd56,  9'd64,  9'd32};
      4'd5:    row = '{9'd160, 9'd80,  9'd64,  9'd80,  9'd40};
      4'd6:    row = '{9'd192, 9'd96,  9'd80,  9'd96,  9'd48};
      4'd7:    row = '{9'd224, 9'd112, 9'd96,  9'd112, 9'd56};
      4'd8:    row = '{9'd256, 9'd128, 9'd112, 9'd128, 9'd64};
      4'd9:    row = '{9'd288, 9'd160, 9'd128, 9'd144, 9'd80};
      4'd10:   row = '{9'd320, 9'd192, 9'd160, 9'd160, 9'd96};
      4'd11:   row = '{9'd352, 9'd224, 9'd192, 9'd176, 9'd112};
      4'd12:   row = '{9'd384, 9'd256, 9'd224, 9'd192, 9'd128};
      4'd13:   row = '{9'd416, 9'd320, 9'd256, 9'd224, 9'd144};
      4'd14:   row = '{9'd448, 9'd384, 9'd320, 9'd256, 9'd160};
      default: row = '{9'd0,   9'd0,   9'd0,   9'd0,   9'd0};
    endcase
    return row[col];
  endfunction

  // MPEG-2 halves the MPEG-1 rate, MPEG-2.5 quarters it
  function automatic logic [15:0] table_rate_hz(logic [1:0] ver, logic [1:0] srx);
    logic [15:0] hz;
    case (srx)
      2'd0:    hz = 16'd44100;
      2'd1:    hz = 16'd48000;
      2'd2:    hz = 16'd32000;
      default: hz = 16'd0;
    endcase
    if (ver == VER_2) hz = hz >> 1;
    else if (ver == VER_25) hz = hz >> 2;
    return hz;
  endfunction

  function automatic decoded_hdr_t decode_header(logic [31:0] w);
    decoded_hdr_t d;
    logic [1:0]   ver;
    logic         v1;
    int           col;
    int unsigned  bps;
    int unsigned  slots;
    ver              = w[20:19];
    v1               = (ver == VER_1);
    d.mpeg_version   = ver;
    case (w[18:17])
      2'd0:    d.layer_number = LAYER_RSV;
      2'd1:    d.layer_number = LAYER_3;
      2'd2:    d.layer_number = LAYER_2;
      default: d.layer_number = LAYER_1;
    endcase
    d.crc_protected  = ~w[16];
    d.padding_bit    = w[9];
    d.channel_mode   = w[7:6];
    d.mode_extension = w[5:4];
    d.flag_bits      = {w[8], w[3], w[2]};
    d.emphasis_code  = w[1:0];
    d.bitrate_kbps   = '0;
    d.sample_rate_hz = '0;
    d.frame_bytes    = '0;

    if (ver != VER_RSV) begin
      d.sample_rate_hz = table_rate_hz(ver, w[11:10]);
      if (d.layer_number != LAYER_RSV) begin
        if (v1) col = int'(d.layer_number) - 1;
        else col = (d.layer_number == LAYER_1) ? 3 : 4;
        d.bitrate_kbps = table_kbps(col, w[15:12]);
      end
    end

    // Lowest fault code wins
    if (w[31:21] != SYNC_PATTERN) d.status = ST_BAD_SYNC;
    else if (ver == VER_RSV) d.status = ST_RSV_VERSION;
    else if (d.layer_number == LAYER_RSV) d.status = ST_RSV_LAYER;
    else if (d.bitrate_kbps == 0) d.status = ST_BAD_BITRATE;
    else if (d.sample_rate_hz == 0) d.status = ST_BAD_RATE;
    else d.status = ST_OK;

    if (d.status == ST_OK) begin
      bps = int'(d.bitrate_kbps) * 1000;
      if (d.layer_number == LAYER_1) begin
        slots = (12 * bps / d.sample_rate_hz + d.padding_bit) * 4;
      end else if (d.layer_number == LAYER_2 || v1) begin
        slots = 144 * bps / d.sample_rate_hz + d.padding_bit;
      end else begin
        slots = 72 * bps / d.sample_rate_hz + d.padding_bit;
      end
      d.frame_bytes = slots[11:0];
    end
    return d;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Take beats and results at the rising edge; queue the expectation first so that
  // the order within the step never matters
  always @(posedge clk) begin
    decoded_hdr_t want;
    if (!rst) begin
      if (start && !busy) begin
        want = decode_header(header_word);
        if (row_fixed) begin
          want.status      = row_status;
          want.frame_bytes = row_bytes;
        end
        pending_decodes.push_back(want);
      end
      if (strobe) begin
        if (pending_decodes.size() == 0) begin
          $error("result strobe with no header outstanding");
          mismatches++;
        end else begin
          want = pending_decodes.pop_front();
          check_field("status", want.status, status);
          check_field("mpeg_version", want.mpeg_version, mpeg_version);
          check_field("layer_number", want.layer_number, layer_number);
          check_field("crc_protected", want.crc_protected, crc_protected);
          check_field("bitrate_kbps", want.bitrate_kbps, bitrate_kbps);
          check_field("sample_rate_hz", want.sample_rate_hz, sample_rate_hz);
          check_field("padding_bit", want.padding_bit, padding_bit);
          check_field("channel_mode", want.channel_mode, channel_mode);
          check_field("mode_extension", want.mode_extension, mode_extension);
          check_field("flag_bits", want.flag_bits, flag_bits);
          check_field("emphasis_code", want.emphasis_code, emphasis_code);
          check_field("frame_bytes", want.frame_bytes, frame_bytes);
        end
      end
    end
    beat_seen = !rst && start && !busy;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL mpeg_audio_frame_header_decoder_unit");
      $finish;
    end
  end

  // Offer one header at the falling edge and hold it until its beat is taken
  task automatic send_header(logic [31:0] w, logic fixed, status_t st, logic [11:0] nbytes,
                             int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    header_word <= w;
    row_fixed   <= fixed;
    row_status  <= st;
    row_bytes   <= nbytes;
    @(negedge clk);
    while (!beat_seen) @(negedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly well-formed headers with random content, then broken ones and raw noise
  function automatic logic [31:0] random_header();
    logic [31:0] w;
    int          r;
    int          pos;
    w = $urandom;
    w[31:21] = SYNC_PATTERN;
    case ($urandom_range(0, 2))
      0:       w[20:19] = VER_25;
      1:       w[20:19] = VER_2;
      default: w[20:19] = VER_1;
    endcase
    w[18:17] = 2'($urandom_range(1, 3));
    w[15:12] = 4'($urandom_range(1, 14));
    w[11:10] = 2'($urandom_range(0, 2));
    r = $urandom_range(0, 99);
    if (r >= 90) begin
      w = $urandom;
    end else if (r >= 75) begin
      case ($urandom_range(0, 4))
        0: begin
          pos = $urandom_range(21, 31);
          w[pos] = ~w[pos];
        end
        1:       w[20:19] = VER_RSV;
        2:       w[18:17] = 2'd0;
        3:       w[15:12] = $urandom_range(0, 1) ? 4'd15 : 4'd0;
        default: w[11:10] = 2'd3;
      endcase
    end
    return w;
  endfunction

  initial begin
    int gap;
    rst         = 1'b1;
    start       = 1'b0;
    header_word = '0;
    row_fixed   = 1'b0;
    row_status  = ST_OK;
    row_bytes   = '0;
    mismatches  = 0;
    cycle_count = 0;
    beat_seen   = 1'b0;

    header_rows = '{
      // largest MPEG-1 Layer I frame, 448 kbps at 32 kHz
      '{32'hFFFFE800, 1'b1, ST_OK, 12'd672},
      // MPEG-1 Layer II 384 kbps at 32 kHz, padded, CRC, all low bits set
      '{32'hFFFCEBFF, 1'b1, ST_OK, 12'd1729},
      // MPEG-1 Layer III 128 kbps at 44.1 kHz, padded
      '{32'hFFFB9200, 1'b1, ST_OK, 12'd418},
      // longest frame: MPEG-2.5 Layer II 160 kbps at 8 kHz, padded
      '{32'hFFE5EA00, 1'b1, ST_OK, 12'd2881},
      // MPEG-2.5 Layer I 256 kbps at 8 kHz, padded slot counts four bytes
      '{32'hFFE7EA00, 1'b1, ST_OK, 12'd1540},
      // shortest Layer I frame, 32 kbps at 48 kHz
      '{32'hFFFF1400, 1'b1, ST_OK, 12'd32},
      // MPEG-2 Layer III 8 kbps at 24 kHz
      '{32'hFFF31400, 1'b1, ST_OK, 12'd24},
      // sync faults: all zero, one sync bit low, top bit low
      '{32'h00000000, 1'b1, ST_BAD_SYNC, 12'd0},
      '{32'hFFDFFFFF, 1'b1, ST_BAD_SYNC, 12'd0},
      '{32'h7FE80000, 1'b1, ST_BAD_SYNC, 12'd0},
      // all ones: bitrate index 15
      '{32'hFFFFFFFF, 1'b1, ST_BAD_BITRATE, 12'd0},
      // reserved version, alone and with reserved layer
      '{32'hFFEF9000, 1'b1, ST_RSV_VERSION, 12'd0},
      '{32'hFFE91000, 1'b1, ST_RSV_VERSION, 12'd0},
      // reserved layer
      '{32'hFFF95000, 1'b1, ST_RSV_LAYER, 12'd0},
      // free format
      '{32'hFFFB0000, 1'b1, ST_BAD_BITRATE, 12'd0},
      // reserved sample rate, alone and behind a bad bitrate
      '{32'hFFFB9C00, 1'b1, ST_BAD_RATE, 12'd0},
      '{32'hFFF5FC00, 1'b1, ST_BAD_BITRATE, 12'd0},
      // remaining layer and version columns, checked by the decoder model
      '{32'hFFF692AA, 1'b0, ST_OK, 12'd0},
      '{32'hFFF58555, 1'b0, ST_OK, 12'd0},
      '{32'hFFE2E200, 1'b0, ST_OK, 12'd0},
      '{32'hFFFD1000, 1'b0, ST_OK, 12'd0},
      '{32'hFFE31800, 1'b0, ST_OK, 12'd0},
      '{32'hFFF7E800, 1'b0, ST_OK, 12'd0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows go back to back, with a few gaps mixed in
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      gap = (i % 5 == 4) ? $urandom_range(1, 3) : 0;
      send_header(header_rows[i].word, header_rows[i].fixed_result,
                  header_rows[i].status, header_rows[i].frame_bytes, gap);
    end

    // Hold the sender until every directed result is back
    start <= 1'b0;
    while (pending_decodes.size() != 0) @(negedge clk);

    for (int i = 0; i < RANDOM_HEADERS; i++) begin
      // Every few hundred beats, run a burst with no gaps at all
      gap = ((i % 300) < 40) ? 0 : pick_gap();
      send_header(random_header(), 1'b0, ST_OK, 12'd0, gap);
      if (i == RANDOM_HEADERS / 2) begin
        start <= 1'b0;
        while (pending_decodes.size() != 0) @(negedge clk);
      end
    end
    start <= 1'b0;

    // Drain, then allow a stray strobe time to show up
    while (pending_decodes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS mpeg_audio_frame_header_decoder_unit");
    end else begin
      $display("FAIL mpeg_audio_frame_header_decoder_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/mafhd_pkg.sv
hw/rtl/mafhd_len_div.sv
hw/rtl/mpeg_audio_frame_header_decoder_unit.sv
test/mpeg_audio_frame_header_decoder_unit_tb.sv
